// File: rtl/desw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// desw_pkg
// Shared types and constants for the decimal entry square wave generator.
// ----------------------------------------------------------------------------
package desw_pkg;

    // Event codes carried by the input opcode field
    typedef enum logic [1:0] {
        OP_DIGIT = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIVIDE,
        ST_RELOAD,
        ST_COMMIT
    } state_t;

    localparam int CNT_W    = 16;   // reload counter width
    localparam int VAL_W    = 14;   // entered decimal value
    localparam int CNTD_W   = 3;    // digits held
    localparam int DIGIT_W  = 4;
    localparam int DVSR_W   = 22;   // 217 * 9999 fits in 22 bits
    localparam int DVND_W   = 27;   // 1e8 fits in 27 bits
    localparam int STEP_W   = 5;    // indexes the dividend bits

    localparam logic [DVND_W-1:0]  SCALED_CLOCK = 27'd100000000;
    localparam logic [DVND_W-1:0]  RELOAD_BASE  = 27'd65545;
    localparam logic [7:0]         DIVISOR_STEP = 8'd217;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;
    localparam logic [STEP_W-1:0]  LAST_STEP    = 5'(DVND_W - 1);

    typedef struct packed {
        logic load_item;
        logic div_load;
        logic div_step;
        logic rel_load;
        logic commit;
    } desw_cmd_t;

    typedef struct packed {
        logic is_start;
        logic value_zero;
        logic div_last;
    } desw_status_t;

endpackage
`default_nettype wire

// File: rtl/desw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// desw_ctrl
// Sequencer: takes one transaction, steps the divider for a start with a
// non-zero value, and commits the result into the output register once it is free.
// ----------------------------------------------------------------------------
module desw_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire                    m_ready,
    input  desw_pkg::desw_status_t status,
    output desw_pkg::desw_cmd_t    cmd
);

    desw_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= desw_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            desw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = desw_pkg::ST_DECODE;
                end
            end
            desw_pkg::ST_DECODE: begin
                if (status.is_start && !status.value_zero) begin
                    cmd.div_load = 1'b1;
                    state_next   = desw_pkg::ST_DIVIDE;
                end else begin
                    state_next   = desw_pkg::ST_COMMIT;
                end
            end
            desw_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = desw_pkg::ST_RELOAD;
                end
            end
            desw_pkg::ST_RELOAD: begin
                cmd.rel_load = 1'b1;
                state_next   = desw_pkg::ST_COMMIT;
            end
            desw_pkg::ST_COMMIT: begin
                // hold until the previous result has been taken
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = desw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = desw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/desw_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// desw_dp
// Datapath: digit entry, reload word computation by restoring division,
// period counter, wave level and the output register.
// ----------------------------------------------------------------------------
module desw_dp #(
    parameter int NUM_DIGITS = 4
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire  [1:0]             s_opcode,
    input  wire  [3:0]             s_digit_value,
    input  desw_pkg::desw_cmd_t    cmd,
    output desw_pkg::desw_status_t status,
    output logic                   m_wave_level,
    output logic                   m_running,
    output logic [15:0]            m_reload_value,
    output logic [13:0]            m_entered_value,
    output logic [2:0]             m_digits_held,
    output logic                   m_zero_rejected
);

    localparam int VW = desw_pkg::VAL_W;
    localparam int CW = desw_pkg::CNT_W;
    localparam int DW = desw_pkg::DVSR_W;
    localparam int NW = desw_pkg::DVND_W;

    // captured transaction
    desw_pkg::op_t                 op_reg;
    logic [desw_pkg::DIGIT_W-1:0]  digit_reg;

    // architectural state
    logic [VW-1:0]                 entered_reg, entered_next;
    logic [desw_pkg::CNTD_W-1:0]   count_reg, count_next;
    logic [CW-1:0]                 reload_word_reg, reload_word_next;
    logic [CW-1:0]                 counter_reg, counter_next;
    logic                          run_reg, run_next;
    logic                          level_reg, level_next;
    logic                          rejected;

    // divider
    logic [DW-1:0]                 divisor_reg;
    logic [DW-1:0]                 rem_reg, rem_next;
    logic [NW-1:0]                 quot_reg;
    logic [desw_pkg::STEP_W-1:0]   step_reg;
    logic [DW:0]                   trial;
    logic                          qbit;
    logic [NW-1:0]                 q_ceil;
    logic [CW-1:0]                 reload_calc_reg;
    logic [VW+3:0]                 times_ten;

    assign status.is_start   = (op_reg == desw_pkg::OP_START);
    assign status.value_zero = (entered_reg == '0);
    assign status.div_last   = (step_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= desw_pkg::op_t'(s_opcode);
            digit_reg <= s_digit_value;
        end
    end

    // one quotient bit per cycle, dividend bits taken MSB first
    always_comb begin
        trial    = {rem_reg, desw_pkg::SCALED_CLOCK[step_reg]};
        qbit     = (trial >= {1'b0, divisor_reg});
        rem_next = qbit ? DW'(trial - {1'b0, divisor_reg}) : DW'(trial);
        q_ceil   = quot_reg + NW'(rem_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            divisor_reg <= DW'({8'd0, entered_reg} * DW'(desw_pkg::DIVISOR_STEP));
            rem_reg     <= '0;
            quot_reg    <= '0;
            step_reg    <= desw_pkg::LAST_STEP;
        end else if (cmd.div_step) begin
            rem_reg     <= rem_next;
            quot_reg    <= {quot_reg[NW-2:0], qbit};
            step_reg    <= step_reg - 1'b1;
        end
        if (cmd.rel_load) begin
            // saturate at zero when the period is too long
            reload_calc_reg <= (q_ceil > desw_pkg::RELOAD_BASE) ? '0
                             : CW'(desw_pkg::RELOAD_BASE - q_ceil);
        end
    end

    always_comb begin
        entered_next     = entered_reg;
        count_next       = count_reg;
        reload_word_next = reload_word_reg;
        counter_next     = counter_reg;
        run_next         = run_reg;
        level_next       = level_reg;
        rejected         = 1'b0;
        times_ten        = {entered_reg, 3'b000} + {2'b00, entered_reg, 1'b0};
        case (op_reg)
            desw_pkg::OP_DIGIT: begin
                if (digit_reg <= desw_pkg::DIGIT_MAX &&
                    count_reg < desw_pkg::CNTD_W'(NUM_DIGITS)) begin
                    entered_next = VW'(times_ten + {(VW)'(0), digit_reg});
                    count_next   = count_reg + 1'b1;
                end
            end
            desw_pkg::OP_START: begin
                if (entered_reg == '0) begin
                    rejected = 1'b1;
                end else begin
                    reload_word_next = reload_calc_reg;
                    counter_next     = reload_calc_reg;
                    run_next         = 1'b1;
                end
            end
            desw_pkg::OP_STOP: begin
                run_next     = 1'b0;
                entered_next = '0;
                count_next   = '0;
            end
            default: begin
                if (run_reg) begin
                    if (counter_reg == '1) begin
                        counter_next = reload_word_reg;
                        level_next   = !level_reg;
                    end else begin
                        counter_next = counter_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entered_reg     <= '0;
            count_reg       <= '0;
            reload_word_reg <= '0;
            counter_reg     <= '0;
            run_reg         <= 1'b0;
            level_reg       <= 1'b0;
        end else if (cmd.commit) begin
            entered_reg     <= entered_next;
            count_reg       <= count_next;
            reload_word_reg <= reload_word_next;
            counter_reg     <= counter_next;
            run_reg         <= run_next;
            level_reg       <= level_next;
        end
    end

    // output register, loaded with the post-update state
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_wave_level    <= level_next;
            m_running       <= run_next;
            m_reload_value  <= reload_word_next;
            m_entered_value <= entered_next;
            m_digits_held   <= count_next;
            m_zero_rejected <= rejected;
        end
    end

endmodule
`default_nettype wire

// File: rtl/decimal_entry_square_wave_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_entry_square_wave_generator_core
// Keypad-style decimal entry driving a reloadable 16-bit square wave counter.
// ----------------------------------------------------------------------------
// One transaction in gives one result out. Digit, stop and tick events go
// through the decode and commit states; a start with a non-zero value also
// runs the 27-step restoring divider that forms ceil(1e8 / (217 * f)) one
// quotient bit per cycle, then the reload state. A start with value zero is
// refused without the divider. The block works on one transaction at a time:
// s_ready is high only while it is idle, and a finished result sits in the
// output register while the next transaction is taken and processed.
module decimal_entry_square_wave_generator_core #(
    parameter int NUM_DIGITS = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_opcode,
    input  wire  [3:0]  s_digit_value,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_wave_level,
    output logic        m_running,
    output logic [15:0] m_reload_value,
    output logic [13:0] m_entered_value,
    output logic [2:0]  m_digits_held,
    output logic        m_zero_rejected
);

    desw_pkg::desw_cmd_t    cmd;
    desw_pkg::desw_status_t status;

    desw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    desw_dp #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_opcode        (s_opcode),
        .s_digit_value   (s_digit_value),
        .cmd             (cmd),
        .status          (status),
        .m_wave_level    (m_wave_level),
        .m_running       (m_running),
        .m_reload_value  (m_reload_value),
        .m_entered_value (m_entered_value),
        .m_digits_held   (m_digits_held),
        .m_zero_rejected (m_zero_rejected)
    );

endmodule
`default_nettype wire

// File: rtl/desw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// desw_checker
// Port-level checks for the square wave generator core.
// ----------------------------------------------------------------------------
module desw_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire        m_wave_level,
    input wire        m_running,
    input wire [15:0] m_reload_value,
    input wire [13:0] m_entered_value,
    input wire [2:0]  m_digits_held,
    input wire        m_zero_rejected
);

    // a stalled result must hold
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reload_value)
                                && $stable(m_entered_value) && $stable(m_wave_level))
        else $error("result changed while stalled");

    // one transaction at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_rejected |-> m_entered_value == 14'd0)
        else $error("start refused with a non-zero value");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_digits_held <= 3'd4 && m_entered_value <= 14'd9999)
        else $error("digit state out of range");

endmodule

bind decimal_entry_square_wave_generator_core desw_checker u_desw_checker (.*);
`default_nettype wire
